### rtl/core/oahi_pkg.sv
// Shared constants, types and hash helpers for the open-addressing hash insert block.
package oahi_pkg;

    // Table geometry; SLOTS is a power of two so slot arithmetic wraps by truncation.
    localparam int SLOTS = 256;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int KEY_W = 16;
    localparam int OUT_W = 12;

    // Hash constants
    localparam int MUL_START = 23;
    localparam int MUL_STEP  = 73;
    localparam int MOD_STEP  = 101;
    localparam int PROD_S_W  = 21;  // 23 * key
    localparam int PROD_T_W  = 23;  // 73 * key
    localparam int QUO_W     = 16;  // (73 * key) / 101
    localparam int STEP_W    = 7;   // remainder below 101
    localparam int RCP_SHIFT = 30;
    localparam int RCP_W     = 24;
    localparam int RCP_PROD_W = PROD_T_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP_101 = 24'd10631108; // ceil(2^30 / 101)

    // Item kinds and probe modes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH2 = 5'b00010,
        S_HASH3 = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic capture;   // take key, form products
        logic clear;     // drop every valid bit, zero result
        logic hash2;     // reciprocal multiply, start slot reduction
        logic hash3;     // remainder, load probe index and step
        logic probe;     // test one slot
        logic out_load;  // move result into output register
    } t_cmd;

    typedef struct packed {
        logic slot_busy;
        logic last_probe;
        logic out_free;
    } t_status;

    // key mod 7 by folding 3-bit digits (8 == 1 mod 7)
    function automatic logic [2:0] mod7(input logic [KEY_W-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

    // value mod 127 by folding 7-bit digits (128 == 1 mod 127)
    function automatic logic [6:0] mod127(input logic [PROD_S_W-1:0] v);
        logic [8:0] s1;
        logic [7:0] s2;
        s1 = 9'(v[6:0]) + 9'(v[13:7]) + 9'(v[20:14]);
        s2 = 8'(s1[6:0]) + 8'(s1[8:7]);
        return (s2 >= 8'd127) ? 7'(s2 - 8'd127) : s2[6:0];
    endfunction

endpackage

### rtl/core/oahi_ctrl.sv
// Sequencer for the hash insert block: accept, hash stages, probe loop, hand-off.
module oahi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  oahi_pkg::t_status i_status,
    output oahi_pkg::t_cmd    o_cmd,
    output logic              o_ready
);

    oahi_pkg::t_state r_state;
    oahi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oahi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            oahi_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_kind == oahi_pkg::KIND_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state     = oahi_pkg::S_DONE;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = oahi_pkg::S_HASH2;
                    end
                end
            end
            oahi_pkg::S_HASH2: begin
                o_cmd.hash2 = 1'b1;
                n_state     = oahi_pkg::S_HASH3;
            end
            oahi_pkg::S_HASH3: begin
                o_cmd.hash3 = 1'b1;
                n_state     = oahi_pkg::S_PROBE;
            end
            oahi_pkg::S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (!i_status.slot_busy || i_status.last_probe) begin
                    n_state = oahi_pkg::S_DONE;
                end
            end
            oahi_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = oahi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oahi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/oahi_dp.sv
// Datapath: hash arithmetic, slot table, probe counters and output register.
module oahi_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oahi_pkg::t_cmd                i_cmd,
    input  logic [oahi_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_stall,
    output oahi_pkg::t_status             o_status,
    output logic                          o_valid,
    output logic [oahi_pkg::OUT_W-1:0]    o_collisions,
    output logic                          o_placed,
    output logic [oahi_pkg::OUT_W-1:0]    o_slot_index
);

    logic                           r_probe_mode;
    logic [oahi_pkg::SLOTS-1:0]     r_slot_valid;
    logic [oahi_pkg::KEY_W-1:0]     r_slot_keys [oahi_pkg::SLOTS];

    logic [oahi_pkg::KEY_W-1:0]     r_key;
    logic [oahi_pkg::PROD_S_W-1:0]  r_prod_s;
    logic [oahi_pkg::PROD_T_W-1:0]  r_prod_t;
    logic [2:0]                     r_start_lin;
    logic [6:0]                     r_start_dbl;
    logic [oahi_pkg::QUO_W-1:0]     r_quo;
    logic [oahi_pkg::IDX_W-1:0]     r_idx;
    logic [oahi_pkg::STEP_W-1:0]    r_step;
    logic [oahi_pkg::IDX_W-1:0]     r_hits;

    logic [oahi_pkg::IDX_W-1:0]     r_res_coll;
    logic                           r_res_placed;
    logic [oahi_pkg::IDX_W-1:0]     r_res_slot;

    logic                           r_out_valid;
    logic [oahi_pkg::OUT_W-1:0]     r_out_coll;
    logic                           r_out_placed;
    logic [oahi_pkg::OUT_W-1:0]     r_out_slot;

    logic [oahi_pkg::RCP_PROD_W-1:0] w_rcp_prod;
    logic [oahi_pkg::PROD_T_W-1:0]   w_quo_x101;
    logic [oahi_pkg::PROD_T_W-1:0]   w_rem;
    logic [oahi_pkg::IDX_W:0]        w_idx_sum;

    always_comb begin
        w_rcp_prod = oahi_pkg::RCP_PROD_W'(r_prod_t)
                   * oahi_pkg::RCP_PROD_W'(oahi_pkg::RECIP_101);
        w_quo_x101 = oahi_pkg::PROD_T_W'(r_quo)
                   * oahi_pkg::PROD_T_W'(oahi_pkg::MOD_STEP);
        w_rem      = r_prod_t - w_quo_x101;
        w_idx_sum  = (oahi_pkg::IDX_W+1)'(r_idx) + (oahi_pkg::IDX_W+1)'(r_step);
    end

    assign o_status.slot_busy  = r_slot_valid[r_idx];
    assign o_status.last_probe = (r_hits == oahi_pkg::IDX_W'(oahi_pkg::SLOTS - 1));
    assign o_status.out_free   = !r_out_valid || !i_stall;

    // Control state: mode register, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= oahi_pkg::MODE_LINEAR;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_probe_mode <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_slot_valid <= '0;
            end else if (i_cmd.probe && !r_slot_valid[r_idx]) begin
                r_slot_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe && !r_slot_valid[r_idx]) begin
            r_slot_keys[r_idx] <= r_key;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key       <= i_key;
            r_prod_s    <= oahi_pkg::PROD_S_W'(i_key)
                         * oahi_pkg::PROD_S_W'(oahi_pkg::MUL_START);
            r_prod_t    <= oahi_pkg::PROD_T_W'(i_key)
                         * oahi_pkg::PROD_T_W'(oahi_pkg::MUL_STEP);
            r_start_lin <= oahi_pkg::mod7(i_key);
        end
        if (i_cmd.hash2) begin
            r_quo       <= w_rcp_prod[oahi_pkg::RCP_SHIFT +: oahi_pkg::QUO_W];
            r_start_dbl <= oahi_pkg::mod127(r_prod_s);
        end
        if (i_cmd.hash3) begin
            r_hits <= '0;
            if (r_probe_mode == oahi_pkg::MODE_DOUBLE) begin
                r_idx  <= oahi_pkg::IDX_W'(r_start_dbl);
                r_step <= w_rem[oahi_pkg::STEP_W-1:0];
            end else begin
                r_idx  <= oahi_pkg::IDX_W'(r_start_lin);
                r_step <= oahi_pkg::STEP_W'(1);
            end
        end
        if (i_cmd.clear) begin
            r_res_coll   <= '0;
            r_res_placed <= 1'b0;
            r_res_slot   <= '0;
        end else if (i_cmd.probe) begin
            if (!r_slot_valid[r_idx]) begin
                r_res_coll   <= r_hits;
                r_res_placed <= 1'b1;
                r_res_slot   <= r_idx;
            end else if (o_status.last_probe) begin
                r_res_coll   <= '0;
                r_res_placed <= 1'b0;
                r_res_slot   <= '0;
            end else begin
                r_idx  <= w_idx_sum[oahi_pkg::IDX_W-1:0];
                r_hits <= r_hits + oahi_pkg::IDX_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_coll   <= oahi_pkg::OUT_W'(r_res_coll);
            r_out_placed <= r_res_placed;
            r_out_slot   <= oahi_pkg::OUT_W'(r_res_slot);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_collisions = r_out_coll;
    assign o_placed     = r_out_placed;
    assign o_slot_index = r_out_slot;

endmodule

### rtl/core/open_addressing_hash_insert.sv
// Top level of the open-addressing hash insert block: sequencer, datapath and checks.
//
// Open-addressing hash table with 256 slots. A clear word drops every valid bit at once;
// an insert word hashes its key and probes until it meets a free slot or has
// seen every probe position occupied. Probe mode 0: start at key mod 7, step 1.
// Probe mode 1: start at (23*key mod 127), step (73*key mod 101); a zero step keeps
// hitting the start slot. Duplicate keys are not looked up, they simply take another
// slot. An insert occupies the block through one capture step, two hash stages, one
// probe per slot tested since the valid bits are read one slot per cycle, and one
// hand-off that waits while a stalled result is held; a clear goes straight to hand-off.
// Input is taken only when the sequencer is idle, but a finished result sits in the
// output register so the next word is taken while that result is still stalled.
// Write probe_mode only while the block is idle.
module open_addressing_hash_insert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [oahi_pkg::KEY_W-1:0]  i_key,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [oahi_pkg::OUT_W-1:0]  o_collisions,
    output logic                        o_placed,
    output logic [oahi_pkg::OUT_W-1:0]  o_slot_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata
);

    oahi_pkg::t_cmd    w_cmd;
    oahi_pkg::t_status w_status;
    logic              w_ready;

    // Sequencer: gates the input and steps through hash and probe phases
    oahi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    // Datapath: hashing, valid bits, key store, output register
    oahi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_key        (i_key),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_stall      (i_stall),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_collisions (o_collisions),
        .o_placed     (o_placed),
        .o_slot_index (o_slot_index)
    );

    assign o_stall = !w_ready;

    // Never overwrite a result that is still held by a stalled receiver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

    // A word taken in must keep the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open directly after accepting a word");

    // Failed insert or clear reports zeros
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_placed) |-> (o_collisions == '0 && o_slot_index == '0))
        else $error("unplaced result carries nonzero fields");

    // Reported slot and collision count stay inside the table
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slot_index < oahi_pkg::OUT_W'(oahi_pkg::SLOTS)
                     && o_collisions < oahi_pkg::OUT_W'(oahi_pkg::SLOTS)))
        else $error("result out of table range");

endmodule
